>>> hdl/dss_pkg.sv
// Shared types, constants and helper functions for the disk seek scheduler.
// No dependencies; every other file imports this package.
`default_nettype none

package dss_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_BITS   = 10;
  localparam int TOTAL_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = TRACK_BITS;
  localparam int POLICY_W     = 2;

  typedef enum logic [POLICY_W-1:0] {
    POL_FCFS = 2'd0,
    POL_SSTF = 2'd1,
    POL_SCAN = 2'd2
  } policy_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 1'b0,
    CFG_START  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } back_state_e;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic [TRACK_BITS-1:0] track;
    logic                  last;
    logic                  keep;
  } dss_req_t;

  function automatic logic [TRACK_BITS-1:0] track_dist(
    input logic [TRACK_BITS-1:0] a,
    input logic [TRACK_BITS-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

>>> hdl/dss_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on dss_pkg for field widths.
`default_nettype none

interface dss_in_if;
  import dss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] track;
  logic                  last_in;
  modport source (output valid, output track, output last_in, input ready);
  modport sink   (input valid, input track, input last_in, output ready);
endinterface

interface dss_out_if;
  import dss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] served_track;
  logic [TRACK_BITS-1:0] seek;
  logic [TOTAL_BITS-1:0] total_seek;
  logic                  last_out;
  modport source (output valid, output served_track, output seek, output total_seek,
                  output last_out, input ready);
  modport sink   (input valid, input served_track, input seek, input total_seek,
                  input last_out, output ready);
endinterface

interface dss_cfg_if;
  import dss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/dss_front.sv
// Front end: accepts requests, counts the batch and marks overflow requests.
// Depends on dss_pkg.
`default_nettype none

module dss_front import dss_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic [TRACK_BITS-1:0] in_track_i,
  input  wire logic     in_last_i,
  output logic          push_valid_o,
  input  wire logic     push_ready_i,
  output dss_req_t      push_req_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             keep;
  logic             accept;

  assign keep         = (count_q < CNT_W'(MAX_REQUESTS));
  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  // A request beyond the store size is dropped unless it closes the batch.
  assign push_valid_o = in_valid_i && (keep || in_last_i);
  assign push_req_o   = '{track: in_track_i, last: in_last_i, keep: keep};

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (in_last_i) begin
        count_d = '0;
      end else if (keep) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dss_queue.sv
// Short request queue between the front end and the scheduling engine.
// Depends on dss_pkg.
`default_nettype none

module dss_queue import dss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  dss_req_t  push_req_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output dss_req_t  pop_req_o
);

  dss_req_t          slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] fill_q;
  logic              push, pop;

  assign push_ready_o = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_req_o    = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/dss_back.sv
// Scheduling engine: stores a batch, then picks each service by a pass over
// the request store and emits one result per pass. Depends on dss_pkg.
`default_nettype none

module dss_back import dss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [POLICY_W-1:0]   policy_i,
  input  wire logic [TRACK_BITS-1:0] start_track_i,
  input  wire logic pop_valid_i,
  output logic      pop_ready_o,
  input  dss_req_t  pop_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [TRACK_BITS-1:0] out_track_o,
  output logic [TRACK_BITS-1:0] out_seek_o,
  output logic [TOTAL_BITS-1:0] out_total_o,
  output logic                  out_last_o
);

  back_state_e state_q, state_d;

  logic [TRACK_BITS-1:0] mem [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] rd_q;
  logic [IDX_W-1:0]      ri_q, ri_d;
  logic                  rv_q, rv_d;
  logic [CNT_W-1:0]      iss_q, iss_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      served_q, served_d;
  logic [MAX_REQUESTS-1:0] flags_q, flags_d;
  logic [TRACK_BITS-1:0] head_q, head_d;
  logic [TOTAL_BITS-1:0] tot_q, tot_d;

  // Primary best (FCFS, SSTF, SCAN upward) and SCAN downward best.
  logic                  a_f_q, a_f_d, b_f_q, b_f_d;
  logic [TRACK_BITS-1:0] a_t_q, a_t_d, b_t_q, b_t_d, a_dist_q, a_dist_d;
  logic [IDX_W-1:0]      a_i_q, a_i_d, b_i_q, b_i_d;

  logic [TRACK_BITS-1:0] out_track_q, out_track_d, out_seek_q, out_seek_d;
  logic [TOTAL_BITS-1:0] out_total_q, out_total_d;
  logic                  out_last_q, out_last_d;

  logic                  pop, wr_en, issue, scan_done, emit_done;
  logic [TRACK_BITS-1:0] cand_dist, sel_t, sel_seek;
  logic [IDX_W-1:0]      sel_i;

  assign pop       = pop_valid_i && pop_ready_o;
  assign wr_en     = pop && pop_req_i.keep;
  assign issue     = (state_q == ST_SCAN) && (iss_q < n_q);
  assign scan_done = (state_q == ST_SCAN) && rv_q && ({1'b0, ri_q} == n_q - 1'b1);
  assign emit_done = (state_q == ST_EMIT) && out_ready_i;
  assign cand_dist = track_dist(head_q, rd_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[n_q[IDX_W-1:0]] <= pop_req_i.track;
    end
    if (issue) begin
      rd_q <= mem[iss_q[IDX_W-1:0]];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (pop && pop_req_i.last) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_EMIT;
      ST_EMIT: if (out_ready_i) state_d = out_last_q ? ST_LOAD : ST_SCAN;
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    pop_ready_o = (state_q == ST_LOAD);
    out_valid_o = (state_q == ST_EMIT);
    out_track_o = out_track_q;
    out_seek_o  = out_seek_q;
    out_total_o = out_total_q;
    out_last_o  = out_last_q;
  end

  // Candidate evaluation for the entry read in the previous cycle.
  always_comb begin
    a_f_d = a_f_q; a_t_d = a_t_q; a_i_d = a_i_q; a_dist_d = a_dist_q;
    b_f_d = b_f_q; b_t_d = b_t_q; b_i_d = b_i_q;
    if (rv_q) begin
      unique case (policy_i)
        POL_SSTF: begin
          if (!flags_q[ri_q] && (!a_f_q || cand_dist < a_dist_q)) begin
            a_f_d = 1'b1; a_t_d = rd_q; a_i_d = ri_q; a_dist_d = cand_dist;
          end
        end
        POL_SCAN: begin
          if (!flags_q[ri_q] && rd_q >= start_track_i && (!a_f_q || rd_q < a_t_q)) begin
            a_f_d = 1'b1; a_t_d = rd_q; a_i_d = ri_q;
          end
          // Equal tracks on the way down go latest arrival first.
          if (!flags_q[ri_q] && rd_q < start_track_i && (!b_f_q || rd_q >= b_t_q)) begin
            b_f_d = 1'b1; b_t_d = rd_q; b_i_d = ri_q;
          end
        end
        default: begin
          if ({1'b0, ri_q} == served_q) begin
            a_f_d = 1'b1; a_t_d = rd_q; a_i_d = ri_q;
          end
        end
      endcase
    end
    sel_t    = a_f_d ? a_t_d : b_t_d;
    sel_i    = a_f_d ? a_i_d : b_i_d;
    sel_seek = track_dist(head_q, sel_t);
  end

  // Datapath next values.
  always_comb begin
    n_d = n_q; served_d = served_q; flags_d = flags_q;
    head_d = head_q; tot_d = tot_q;
    iss_d = iss_q; rv_d = 1'b0; ri_d = ri_q;
    out_track_d = out_track_q; out_seek_d = out_seek_q;
    out_total_d = out_total_q; out_last_d = out_last_q;
    if (wr_en) begin
      n_d = n_q + 1'b1;
    end
    if (issue) begin
      iss_d = iss_q + 1'b1;
      rv_d  = 1'b1;
      ri_d  = iss_q[IDX_W-1:0];
    end
    if (pop && pop_req_i.last) begin
      served_d = '0;
      flags_d  = '0;
      head_d   = start_track_i;
      tot_d    = '0;
      iss_d    = '0;
    end
    if (scan_done) begin
      flags_d[sel_i] = 1'b1;
      head_d         = sel_t;
      tot_d          = tot_q + TOTAL_BITS'(sel_seek);
      served_d       = served_q + 1'b1;
      out_track_d    = sel_t;
      out_seek_d     = sel_seek;
      out_total_d    = tot_q + TOTAL_BITS'(sel_seek);
      out_last_d     = (served_q + 1'b1 == n_q);
    end
    if (emit_done) begin
      iss_d = '0;
      if (out_last_q) begin
        n_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      n_q      <= '0;
      served_q <= '0;
      flags_q  <= '0;
      head_q   <= '0;
      tot_q    <= '0;
      iss_q    <= '0;
      rv_q     <= 1'b0;
      a_f_q    <= 1'b0;
      b_f_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      served_q <= served_d;
      flags_q  <= flags_d;
      head_q   <= head_d;
      tot_q    <= tot_d;
      iss_q    <= iss_d;
      rv_q     <= rv_d;
      if (state_q != ST_SCAN) begin
        a_f_q <= 1'b0;
        b_f_q <= 1'b0;
      end else begin
        a_f_q <= a_f_d;
        b_f_q <= b_f_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q        <= ri_d;
    a_t_q       <= a_t_d;
    a_i_q       <= a_i_d;
    a_dist_q    <= a_dist_d;
    b_t_q       <= b_t_d;
    b_i_q       <= b_i_d;
    out_track_q <= out_track_d;
    out_seek_q  <= out_seek_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
  end

endmodule

`default_nettype wire

>>> hdl/disk_seek_scheduler_unit.sv
// Disk seek scheduler, top level: register file, front end, queue, engine.
// Requests are taken while the engine is loading a batch.
// After the closing request, the engine makes one full pass over the single-port
// request store per service and emits one result per pass.
// Reset clears all control state; policy and start_track reset to zero.
`default_nettype none

module disk_seek_scheduler_unit import dss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dss_cfg_if.sink   cfg_i,
  dss_in_if.sink    in_i,
  dss_out_if.source out_o
);

  logic [POLICY_W-1:0]   policy_q;
  logic [TRACK_BITS-1:0] start_q;
  logic                  push_valid, push_ready, pop_valid, pop_ready;
  dss_req_t              push_req, pop_req;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= '0;
      start_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_POLICY: policy_q <= cfg_i.data[POLICY_W-1:0];
        CFG_START:  start_q  <= cfg_i.data[TRACK_BITS-1:0];
        default:    ;
      endcase
    end
  end

  dss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_track_i   (in_i.track),
    .in_last_i    (in_i.last_in),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_req_o   (push_req)
  );

  dss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  dss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .policy_i      (policy_q),
    .start_track_i (start_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_req_i     (pop_req),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_track_o   (out_o.served_track),
    .out_seek_o    (out_o.seek),
    .out_total_o   (out_o.total_seek),
    .out_last_o    (out_o.last_out)
  );

endmodule

`default_nettype wire
